// ===== src/msqrt_pkg.sv =====
// msqrt_pkg: types and constants for the modular square root core
// no dependencies

package msqrt_pkg;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_CHECK,
    ST_RED,
    ST_EUL_SETUP,
    ST_EUL_DONE,
    ST_SPLIT,
    ST_P3_SETUP,
    ST_Z_SETUP,
    ST_Z_TEST,
    ST_C_SETUP,
    ST_R_SETUP,
    ST_T_SETUP,
    ST_TS_LOOP,
    ST_SQ_MUL,
    ST_SQ_CHK,
    ST_B_MUL,
    ST_R_MUL,
    ST_C_MUL,
    ST_T_MUL,
    ST_POW_STEP,
    ST_POW_WAIT,
    ST_DONE,
    ST_OUT
  } msqrt_state_e;

  typedef enum logic [2:0] {
    PR_EULER,
    PR_P3,
    PR_ZTEST,
    PR_C,
    PR_R,
    PR_T
  } msqrt_pret_e;

  typedef enum logic {
    PH_RES,
    PH_SQR
  } msqrt_phase_e;

endpackage

// ===== src/msqrt_if.sv =====
// msqrt_if: valid/ready channel carrying generic payload
// no dependencies

interface msqrt_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== src/msqrt_mulmod.sv =====
// msqrt_mulmod: bit-serial shift-and-add modular multiplier, one bit per cycle
// depends on msqrt_pkg

module msqrt_mulmod
  import msqrt_pkg::*;
#(
  parameter int MOD_BITS = 31
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [MOD_BITS-1:0] a_i,
  input  logic [MOD_BITS-1:0] b_i,
  input  logic [MOD_BITS-1:0] m_i,
  output logic                busy_o,
  output logic [MOD_BITS-1:0] res_o
);
  localparam int CW = $clog2(MOD_BITS + 1);

  logic [MOD_BITS-1:0] r_q, r_d, b_q, b_d, a_q, m_q;
  logic [CW-1:0]       cnt_q, cnt_d;
  logic                busy_q, busy_d;
  logic [MOD_BITS:0]   dbl, dred, add;
  logic [MOD_BITS-1:0] r2;

  always_comb begin
    dbl  = {r_q, 1'b0};
    dred = (dbl >= {1'b0, m_q}) ? dbl - {1'b0, m_q} : dbl;
    r2   = dred[MOD_BITS-1:0];
    add  = {1'b0, r2} + {1'b0, a_q};
    if (add >= {1'b0, m_q}) add = add - {1'b0, m_q};
    r_d    = r_q;
    b_d    = b_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    if (start_i) begin
      r_d    = '0;
      b_d    = b_i;
      cnt_d  = CW'(MOD_BITS);
      busy_d = 1'b1;
    end else if (busy_q) begin
      r_d   = b_q[MOD_BITS-1] ? add[MOD_BITS-1:0] : r2;
      b_d   = {b_q[MOD_BITS-2:0], 1'b0};
      cnt_d = cnt_q - CW'(1);
      if (cnt_q == CW'(1)) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    r_q <= r_d;
    b_q <= b_d;
    if (start_i) begin
      a_q <= a_i;
      m_q <= m_i;
    end
  end

  assign busy_o = busy_q;
  assign res_o  = r_q;
endmodule

// ===== src/modular_square_root_core.sv =====
// modular_square_root_core: tonelli-shanks modular square root (direct power when p = 3 mod 4), one item at a time
// depends on msqrt_pkg, msqrt_if, msqrt_mulmod
// modular multiplies run one at a time on the bit-serial multiplier; a few hundred
// multiplies per item, more when the non-residue search runs long; the value is first
// reduced mod p bit-serially, one value bit per step
// throughput: one item at a time, input ready only when idle; async active-low reset to idle

module modular_square_root_core
  import msqrt_pkg::*;
#(
  parameter int MOD_BITS = 31
) (
  input logic clk_i,
  input logic rst_ni,
  msqrt_if.sink   in_i,
  msqrt_if.source out_o
);
  localparam int CW = $clog2(MOD_BITS + 1);

  msqrt_state_e st_q, st_d;
  msqrt_pret_e  pret_q, pret_d;
  msqrt_phase_e ph_q, ph_d;

  logic [MOD_BITS-1:0] p_q, n_q, q_q, z_q, c_q, r_q, t_q, sq_q, b_q;
  logic [MOD_BITS-1:0] pres_q, pbase_q, pexp_q;
  logic [MOD_BITS-1:0] p_d, n_d, q_d, z_d, c_d, r_d, t_d, sq_d, b_d;
  logic [MOD_BITS-1:0] pres_d, pbase_d, pexp_d;
  logic [CW-1:0]       s_q, s_d, m_q, m_d, i_q, i_d, j_q, j_d, cnt_q, cnt_d;
  logic [MOD_BITS-1:0] rem_q, rem_d, vsh_q, vsh_d;
  logic [MOD_BITS-1:0] ro_q, ro_d, oro_q, oro_d;
  logic                nr_q, nr_d, ov_q, ov_d;

  logic                mstart, mbusy;
  logic [MOD_BITS-1:0] ma, mb, mres;
  logic [MOD_BITS:0]   rsh;
  logic [MOD_BITS-1:0] one;

  assign one = MOD_BITS'(1);

  msqrt_mulmod #(.MOD_BITS(MOD_BITS)) u_mul (
    .clk_i, .rst_ni, .start_i(mstart), .a_i(ma), .b_i(mb), .m_i(p_q),
    .busy_o(mbusy), .res_o(mres)
  );

  always_comb begin
    st_d = st_q; pret_d = pret_q; ph_d = ph_q;
    p_d = p_q; n_d = n_q; q_d = q_q; z_d = z_q; c_d = c_q; r_d = r_q; t_d = t_q;
    sq_d = sq_q; b_d = b_q; pres_d = pres_q; pbase_d = pbase_q; pexp_d = pexp_q;
    s_d = s_q; m_d = m_q; i_d = i_q; j_d = j_q; cnt_d = cnt_q;
    rem_d = rem_q; vsh_d = vsh_q; ro_d = ro_q; oro_d = oro_q; nr_d = nr_q; ov_d = ov_q;
    mstart = 1'b0; ma = sq_q; mb = sq_q;
    rsh = {rem_q, vsh_q[MOD_BITS-1]};
    unique case (st_q)
      ST_IDLE: if (in_i.valid) begin
        p_d = in_i.data[MOD_BITS-1:0];
        vsh_d = in_i.data[2*MOD_BITS-1:MOD_BITS];
        rem_d = '0; cnt_d = CW'(MOD_BITS);
        st_d = ST_CHECK;
      end
      ST_CHECK: begin
        ro_d = '0; oro_d = '0; nr_d = 1'b1;
        st_d = (p_q < MOD_BITS'(3) || !p_q[0]) ? ST_DONE : ST_RED;
      end
      ST_RED: begin
        rem_d = (rsh >= {1'b0, p_q}) ? MOD_BITS'(rsh - {1'b0, p_q}) : rsh[MOD_BITS-1:0];
        vsh_d = {vsh_q[MOD_BITS-2:0], 1'b0};
        cnt_d = cnt_q - CW'(1);
        if (cnt_q == CW'(1)) begin
          n_d = (rsh >= {1'b0, p_q}) ? MOD_BITS'(rsh - {1'b0, p_q}) : rsh[MOD_BITS-1:0];
          if (n_d == '0) begin
            ro_d = '0; oro_d = p_q; nr_d = 1'b0; st_d = ST_DONE;
          end else st_d = ST_EUL_SETUP;
        end
      end
      ST_EUL_SETUP: begin
        pres_d = one; pbase_d = n_q; pexp_d = p_q >> 1;
        pret_d = PR_EULER; ph_d = PH_RES; st_d = ST_POW_STEP;
      end
      ST_EUL_DONE: begin
        if (pres_q != one) st_d = ST_DONE;
        else begin
          q_d = p_q - one; s_d = '0; st_d = ST_SPLIT;
        end
      end
      ST_SPLIT: begin
        if (!q_q[0]) begin
          q_d = q_q >> 1; s_d = s_q + CW'(1);
        end else if (p_q[1]) st_d = ST_P3_SETUP;
        else begin
          z_d = MOD_BITS'(2); st_d = ST_Z_SETUP;
        end
      end
      ST_P3_SETUP: begin
        pres_d = one; pbase_d = n_q;
        pexp_d = MOD_BITS'(({1'b0, p_q} + 1'b1) >> 2);
        pret_d = PR_P3; ph_d = PH_RES; st_d = ST_POW_STEP;
      end
      ST_Z_SETUP: begin
        if (z_q >= p_q) st_d = ST_DONE;
        else begin
          pres_d = one; pbase_d = z_q; pexp_d = p_q >> 1;
          pret_d = PR_ZTEST; ph_d = PH_RES; st_d = ST_POW_STEP;
        end
      end
      ST_Z_TEST: begin
        if (pres_q != one) st_d = ST_C_SETUP;
        else begin
          z_d = z_q + one; st_d = ST_Z_SETUP;
        end
      end
      ST_C_SETUP: begin
        pres_d = one; pbase_d = z_q; pexp_d = q_q;
        pret_d = PR_C; ph_d = PH_RES; st_d = ST_POW_STEP;
      end
      ST_R_SETUP: begin
        pres_d = one; pbase_d = n_q; pexp_d = (q_q >> 1) + one;
        pret_d = PR_R; ph_d = PH_RES; st_d = ST_POW_STEP;
      end
      ST_T_SETUP: begin
        pres_d = one; pbase_d = n_q; pexp_d = q_q;
        pret_d = PR_T; ph_d = PH_RES; st_d = ST_POW_STEP;
      end
      ST_TS_LOOP: begin
        if (t_q == one) begin
          ro_d = r_q; oro_d = p_q - r_q; nr_d = 1'b0; st_d = ST_DONE;
        end else begin
          sq_d = t_q; i_d = CW'(1); st_d = ST_SQ_CHK;
        end
      end
      ST_SQ_CHK: begin
        if (i_q >= m_q) st_d = ST_DONE;
        else begin
          ma = sq_q; mb = sq_q; mstart = 1'b1; st_d = ST_SQ_MUL;
        end
      end
      ST_SQ_MUL: if (!mbusy) begin
        sq_d = mres;
        if (mres == one) begin
          b_d = c_q; j_d = '0; st_d = ST_B_MUL; ov_d = 1'b0;
        end else begin
          i_d = i_q + CW'(1); st_d = ST_SQ_CHK;
        end
      end
      ST_B_MUL: begin
        if (ov_q) begin
          if (!mbusy) begin
            b_d = mres; j_d = j_q + CW'(1); ov_d = 1'b0;
          end
        end else if ({1'b0, j_q} + {1'b0, i_q} + 1'b1 < {1'b0, m_q}) begin
          ma = b_q; mb = b_q; mstart = 1'b1; ov_d = 1'b1;
        end else begin
          ma = r_q; mb = b_q; mstart = 1'b1; st_d = ST_R_MUL;
        end
      end
      ST_R_MUL: if (!mbusy) begin
        r_d = mres; ma = b_q; mb = b_q; mstart = 1'b1; st_d = ST_C_MUL;
      end
      ST_C_MUL: if (!mbusy) begin
        c_d = mres; ma = t_q; mb = mres; mstart = 1'b1; st_d = ST_T_MUL;
      end
      ST_T_MUL: if (!mbusy) begin
        t_d = mres; m_d = i_q; st_d = ST_TS_LOOP;
      end
      ST_POW_STEP: begin
        if (pexp_q == '0) begin
          unique case (pret_q)
            PR_EULER: st_d = ST_EUL_DONE;
            PR_P3: begin
              ro_d = pres_q; oro_d = p_q - pres_q; nr_d = 1'b0; st_d = ST_DONE;
            end
            PR_ZTEST: st_d = ST_Z_TEST;
            PR_C: begin c_d = pres_q; st_d = ST_R_SETUP; end
            PR_R: begin r_d = pres_q; st_d = ST_T_SETUP; end
            PR_T: begin t_d = pres_q; m_d = s_q; st_d = ST_TS_LOOP; end
            default: st_d = ST_DONE;
          endcase
        end else if (ph_q == PH_RES && pexp_q[0]) begin
          ma = pres_q; mb = pbase_q; mstart = 1'b1; st_d = ST_POW_WAIT;
        end else begin
          ph_d = PH_SQR; ma = pbase_q; mb = pbase_q; mstart = 1'b1; st_d = ST_POW_WAIT;
        end
      end
      ST_POW_WAIT: if (!mbusy) begin
        if (ph_q == PH_RES) begin
          pres_d = mres; ph_d = PH_SQR;
        end else begin
          pbase_d = mres; pexp_d = pexp_q >> 1; ph_d = PH_RES;
        end
        st_d = ST_POW_STEP;
      end
      ST_DONE: st_d = ST_OUT;
      ST_OUT: if (out_o.ready) st_d = ST_IDLE;
      default: st_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_IDLE;
      pret_q <= PR_EULER;
      ph_q <= PH_RES;
      ov_q <= 1'b0;
    end else begin
      st_q <= st_d;
      pret_q <= pret_d;
      ph_q <= ph_d;
      ov_q <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    p_q <= p_d; n_q <= n_d; q_q <= q_d; z_q <= z_d; c_q <= c_d; r_q <= r_d; t_q <= t_d;
    sq_q <= sq_d; b_q <= b_d; pres_q <= pres_d; pbase_q <= pbase_d; pexp_q <= pexp_d;
    s_q <= s_d; m_q <= m_d; i_q <= i_d; j_q <= j_d; cnt_q <= cnt_d;
    rem_q <= rem_d; vsh_q <= vsh_d; ro_q <= ro_d; oro_q <= oro_d; nr_q <= nr_d;
  end

  assign in_i.ready  = (st_q == ST_IDLE);
  assign out_o.valid = (st_q == ST_OUT);
  assign out_o.data  = {nr_q, oro_q, ro_q};
endmodule

// ===== src/msqrt_checker.sv =====
// msqrt_checker: port-level assertions for modular_square_root_core
// depends on msqrt_if and modular_square_root_core

module msqrt_checker #(
  parameter int MOD_BITS = 31
) (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_valid,
  input logic                  in_ready,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic [2*MOD_BITS:0]   out_data
);
  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready && out_valid)) else $error("ready while result pending");
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid && in_ready) |=> !in_ready) else $error("ready after accept");
  a_noroot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid && out_data[2*MOD_BITS]) |-> (out_data[MOD_BITS-1:0] == '0))
    else $error("root nonzero with no_root");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
    else $error("result dropped");
endmodule

bind modular_square_root_core msqrt_checker #(.MOD_BITS(MOD_BITS)) u_chk (
  .clk_i, .rst_ni, .in_valid(in_i.valid), .in_ready(in_i.ready),
  .out_valid(out_o.valid), .out_ready(out_o.ready), .out_data(out_o.data)
);

// ===== test/tb_top.sv =====
// tb_top: self-checking testbench for modular_square_root_core
// depends on msqrt_pkg, msqrt_if and the core; predicts roots with a local tonelli-shanks model
`timescale 1ns / 1ps

module tb_top;
  import msqrt_pkg::*;

  localparam int MOD_BITS = 31;
  localparam longint unsigned FMASK = (64'd1 << MOD_BITS) - 1;

  typedef struct packed {
    logic [MOD_BITS-1:0] value;
    logic [MOD_BITS-1:0] modulus;
  } sqrt_req_t;

  typedef struct packed {
    logic                no_root;
    logic [MOD_BITS-1:0] other_root;
    logic [MOD_BITS-1:0] root;
  } sqrt_rsp_t;

  logic clk_i;
  logic rst_ni;
  logic quiet;
  int   errors;
  sqrt_rsp_t roots_q[$];

  msqrt_if #(.payload_t(sqrt_req_t)) req_if ();
  msqrt_if #(.payload_t(sqrt_rsp_t)) rsp_if ();

  modular_square_root_core #(.MOD_BITS(MOD_BITS)) u_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (req_if.sink),
    .out_o (rsp_if.source)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  function automatic longint unsigned mulmod(longint unsigned a, longint unsigned b,
                                             longint unsigned m);
    longint unsigned acc;
    acc = 0;
    for (int k = 63; k >= 0; k--) begin
      acc = acc + acc;
      if (acc >= m) acc -= m;
      if (b[k]) begin
        acc = acc + a;
        if (acc >= m) acc -= m;
      end
    end
    return acc;
  endfunction

  function automatic longint unsigned powmod(longint unsigned b, longint unsigned e,
                                             longint unsigned m);
    longint unsigned acc, sq;
    acc = 1 % m;
    sq = b % m;
    while (e != 0) begin
      if (e[0]) acc = mulmod(acc, sq, m);
      sq = mulmod(sq, sq, m);
      e >>= 1;
    end
    return acc;
  endfunction

  function automatic bit qr(longint unsigned x, longint unsigned p);
    return powmod(x, (p - 1) >> 1, p) == 1;
  endfunction

  function automatic sqrt_rsp_t sqrt_mod_expect(sqrt_req_t req);
    sqrt_rsp_t rsp;
    longint unsigned p, n, q, s, z, c, r, t, m, sq, i, b;
    bit ok;
    rsp = '{root: '0, other_root: '0, no_root: 1'b1};
    p = 64'(req.modulus);
    if (p < 3 || !p[0]) return rsp;
    n = 64'(req.value) % p;
    if (n == 0) begin
      rsp.other_root = MOD_BITS'(p);
      rsp.no_root = 1'b0;
      return rsp;
    end
    if (!qr(n, p)) return rsp;
    q = p - 1;
    s = 0;
    while (!q[0]) begin
      q >>= 1;
      s++;
    end
    ok = 1'b1;
    if (p[1:0] == 2'b11) begin
      r = powmod(n, (p + 1) >> 2, p);
    end else begin
      for (z = 2; z < p; z++)
        if (!qr(z, p)) break;
      if (z >= p) return rsp;
      c = powmod(z, q, p);
      r = powmod(n, (q + 1) >> 1, p);
      t = powmod(n, q, p);
      m = s;
      while (ok && t != 1) begin
        sq = t;
        for (i = 1; i < m; i++) begin
          sq = mulmod(sq, sq, p);
          if (sq == 1) break;
        end
        if (i >= m) begin
          ok = 1'b0;
        end else begin
          b = c;
          for (longint unsigned j = 0; j + i + 1 < m; j++) b = mulmod(b, b, p);
          r = mulmod(r, b, p);
          c = mulmod(b, b, p);
          t = mulmod(t, c, p);
          m = i;
        end
      end
    end
    if (!ok) return rsp;
    rsp.root = MOD_BITS'(r & FMASK);
    rsp.other_root = MOD_BITS'((p - r) & FMASK);
    rsp.no_root = 1'b0;
    return rsp;
  endfunction

  task automatic send_item(longint unsigned value, longint unsigned modulus);
    sqrt_req_t req;
    int gap;
    req.value = value[MOD_BITS-1:0];
    req.modulus = modulus[MOD_BITS-1:0];
    gap = quiet ? 0 : (($urandom_range(99) < 10) ? $urandom_range(1, 6) : 0);
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid <= 1'b1;
    req_if.data <= req;
    do @(posedge clk_i); while (!req_if.ready);
    roots_q.push_back(sqrt_mod_expect(req));
  endtask

  task automatic drain();
    req_if.valid <= 1'b0;
    @(posedge clk_i);
    while (roots_q.size() != 0) @(posedge clk_i);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
    end else begin
      rsp_if.ready <= quiet ? 1'b1 : ($urandom_range(99) >= 10);
    end
  end

  always @(posedge clk_i) begin
    sqrt_rsp_t want;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      if (roots_q.size() == 0) begin
        $display("%0t: unexpected item %p", $time, rsp_if.data);
        errors++;
      end else begin
        want = roots_q.pop_front();
        if (rsp_if.data.root !== want.root) begin
          $display("%0t: root exp %0d got %0d", $time, want.root, rsp_if.data.root);
          errors++;
        end
        if (rsp_if.data.other_root !== want.other_root) begin
          $display("%0t: other_root exp %0d got %0d", $time, want.other_root,
                   rsp_if.data.other_root);
          errors++;
        end
        if (rsp_if.data.no_root !== want.no_root) begin
          $display("%0t: no_root exp %0b got %0b", $time, want.no_root, rsp_if.data.no_root);
          errors++;
        end
      end
    end
  end

  longint unsigned primes[] = '{3, 5, 7, 13, 17, 41, 97, 257, 7681, 12289, 65537,
                                998244353, 1000000007, 1000000009, 2013265921,
                                2147483629, 2147483647};

  task automatic test_directed();
    send_item(0, 2147483647);
    send_item(FMASK, 2147483647);
    send_item(FMASK, 2147483629);
    send_item(2147483647, 2147483647);
    send_item(4, 13);
    send_item(3, 13);
    send_item(10, 13);
    send_item(2, 17);
    send_item(3, 17);
    send_item(5, 2013265921);
    send_item(4, 998244353);
    send_item(1, 3);
    send_item(2, 3);
    send_item(7, 0);
    send_item(7, 1);
    send_item(7, 2);
    send_item(7, 1000);
    send_item(FMASK, FMASK - 1);
    send_item(4, 15);
    send_item(16, 45);
    send_item(1, 65537);
    send_item(123456789, 1000000009);
  endtask

  task automatic test_random(int count);
    longint unsigned p, v;
    for (int k = 0; k < count; k++) begin
      quiet = (k >= count / 3) && (k < count / 2);
      v = {$urandom} & FMASK;
      case ($urandom_range(9))
        0: p = $urandom_range(4095);
        1: p = {$urandom} & FMASK;
        default: p = primes[$urandom_range(primes.size() - 1)];
      endcase
      if ($urandom_range(3) == 0 && p > 2) v = mulmod(v % p, v % p, p);
      send_item(v, p);
    end
    quiet = 1'b0;
  endtask

  task automatic test_pause();
    drain();
    send_item(9, 1000000009);
    send_item(0, 97);
  endtask

  initial begin
    errors = 0;
    quiet = 1'b0;
    rst_ni = 1'b0;
    req_if.valid = 1'b0;
    req_if.data = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_pause();
    test_random(100);
    drain();
    repeat (200) @(posedge clk_i);
    if (errors == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

  initial begin
    #1_000_000_000;
    $display("tb_top: done, errors");
    $finish;
  end

endmodule
